[rtl/core/bpc_pkg.sv]
// Shared types, constants and helper functions for the barometer compensation core.
// No dependencies; the top level, bpc_div and bpc_press import this package (bpc_if does not).
package bpc_pkg;

  localparam int DivStages = 32;

  localparam logic [2:0] CfgAc1Ac2 = 3'd0;
  localparam logic [2:0] CfgAc3Ac4 = 3'd1;
  localparam logic [2:0] CfgAc5Ac6 = 3'd2;
  localparam logic [2:0] CfgB1B2   = 3'd3;
  localparam logic [2:0] CfgMcMd   = 3'd4;
  localparam logic [2:0] CfgOss    = 3'd5;

  localparam logic [1:0]  OssReset    = 2'd1;
  localparam logic [31:0] TempOffset  = 32'd4000;
  localparam logic [31:0] HalfScale   = 32'd32768;
  localparam logic [15:0] PressScale  = 16'd50000;
  localparam logic [31:0] SqCoef      = 32'd3038;
  localparam logic [31:0] LinCoef     = 32'hFFFF_E343;
  localparam logic [31:0] FinalOffset = 32'd3791;
  localparam logic [31:0] RoundTwo    = 32'd2;

  typedef struct packed {
    logic [31:0] a;
    logic [18:0] up;
    logic        neg;
    logic        err;
    logic        flag;
  } ctx_t;

  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
    logic [1:0]  oss;
  } cal_t;

  typedef struct packed {
    logic        vld;
    logic        terr;
    logic [18:0] up;
    logic [31:0] x1;
    logic [31:0] x2;
  } press_in_t;

  typedef struct packed {
    logic        vld;
    logic        terr;
    logic [31:0] b5;
    logic [31:0] b4;
    logic [31:0] b7;
  } press_out_t;

  function automatic logic [31:0] sx16(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  // One restoring step: returns the new remainder and the shifted quotient word.
  function automatic logic [63:0] div_step(input logic [31:0] rem, input logic [31:0] quo,
                                           input logic [31:0] dvs);
    logic [32:0] sh;
    logic [33:0] diff;
    logic [31:0] rem_n;
    logic        qb;
    sh   = {rem, quo[31]};
    diff = {1'b0, sh} - {2'b00, dvs};
    qb   = ~diff[33];
    rem_n = qb ? diff[31:0] : sh[31:0];
    return {rem_n, quo[30:0], qb};
  endfunction

endpackage

[rtl/core/bpc_if.sv]
// Valid/ready channel interfaces for the raw reading input and the compensated result.
// No dependencies.
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [18:0] raw_pressure;
  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_term;
  logic signed [31:0] pressure_pa;
  logic               divide_error;
  modport source (output valid, output temperature_term, output pressure_pa,
                  output divide_error, input ready);
  modport sink (input valid, input temperature_term, input pressure_pa,
                input divide_error, output ready);
endinterface

[rtl/core/barometric_pressure_compensation_core.sv]
// Top level of the barometer compensation core: configuration registers, temperature
// stages, two pipelined dividers and the final pressure correction.
// Depends on bpc_pkg, bpc_if, bpc_div and bpc_press.
//
//   Channel   Direction  Handshake     Contents
//   in_ch     input      valid/ready   raw_temperature, raw_pressure
//   out_ch    output     valid/ready   temperature_term, pressure_pa, divide_error
//   cfg_*     input      write enable  register index and 32-bit write data
//
// One transaction is accepted per cycle while out_ch is not stalled; each result passes through
// the two 32-stage dividers plus fourteen arithmetic stages.
// Reset is synchronous: it clears every valid bit, zeroes calibration, sets oversampling to 1.
// A stall on out_ch holds the whole pipeline in place; in_ch.ready drops for those cycles.
module barometric_pressure_compensation_core (
  input  logic        clk,
  input  logic        rst_n,
  bpc_in_if.sink      in_ch,
  bpc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import bpc_pkg::*;

  logic [31:0] ac1_ac2_r, ac3_ac4_r, ac5_ac6_r, b1_b2_r, mc_md_r;
  logic [1:0]  oss_r;
  cal_t        cal;
  logic        adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_ac2_r <= '0;
      ac3_ac4_r <= '0;
      ac5_ac6_r <= '0;
      b1_b2_r   <= '0;
      mc_md_r   <= '0;
      oss_r     <= OssReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgAc1Ac2: ac1_ac2_r <= cfg_wdata;
        CfgAc3Ac4: ac3_ac4_r <= cfg_wdata;
        CfgAc5Ac6: ac5_ac6_r <= cfg_wdata;
        CfgB1B2:   b1_b2_r   <= cfg_wdata;
        CfgMcMd:   mc_md_r   <= cfg_wdata;
        CfgOss:    oss_r     <= cfg_wdata[1:0];
        default:   ;
      endcase
    end
  end

  assign cal.ac1 = sx16(ac1_ac2_r[31:16]);
  assign cal.ac2 = sx16(ac1_ac2_r[15:0]);
  assign cal.ac3 = sx16(ac3_ac4_r[31:16]);
  assign cal.ac4 = {16'd0, ac3_ac4_r[15:0]};
  assign cal.ac5 = {16'd0, ac5_ac6_r[31:16]};
  assign cal.ac6 = {16'd0, ac5_ac6_r[15:0]};
  assign cal.b1  = sx16(b1_b2_r[31:16]);
  assign cal.b2  = sx16(b1_b2_r[15:0]);
  assign cal.mc  = sx16(mc_md_r[31:16]);
  assign cal.md  = sx16(mc_md_r[15:0]);
  assign cal.oss = oss_r;

  logic out_valid_r;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  logic        a_vld_r;
  logic [31:0] a_prod_r;
  logic [18:0] a_up_r;
  logic [31:0] a_diff;

  assign a_diff = {16'd0, in_ch.raw_temperature} - cal.ac6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_prod_r <= a_diff * cal.ac5;
      a_up_r   <= in_ch.raw_pressure;
    end
  end

  logic [31:0] b_x1, b_den, b_num, b_num_mag, b_den_mag;
  ctx_t        b_ctx;

  assign b_x1      = asr(a_prod_r, 15);
  assign b_den     = b_x1 + cal.md;
  assign b_num     = {cal.mc[20:0], 11'd0};
  assign b_num_mag = b_num[31] ? (32'd0 - b_num) : b_num;
  assign b_den_mag = b_den[31] ? (32'd0 - b_den) : b_den;
  assign b_ctx.a    = b_x1;
  assign b_ctx.up   = a_up_r;
  assign b_ctx.neg  = b_num[31] ^ b_den[31];
  assign b_ctx.err  = (b_den == 32'd0);
  assign b_ctx.flag = 1'b0;

  logic        t_vld;
  logic [31:0] t_quo;
  ctx_t        t_ctx;

  bpc_div u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (a_vld_r),
    .in_dvd    (b_num_mag),
    .in_dvs    (b_den_mag),
    .in_ctx    (b_ctx),
    .out_valid (t_vld),
    .out_quo   (t_quo),
    .out_ctx   (t_ctx)
  );

  logic        c_vld_r, c_terr_r;
  logic [31:0] c_x1_r, c_x2_r;
  logic [18:0] c_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= t_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_terr_r <= t_ctx.err;
      c_x1_r   <= t_ctx.a;
      c_x2_r   <= t_ctx.neg ? (32'd0 - t_quo) : t_quo;
      c_up_r   <= t_ctx.up;
    end
  end

  press_in_t  pin;
  press_out_t pout;

  assign pin.vld  = c_vld_r;
  assign pin.terr = c_terr_r;
  assign pin.up   = c_up_r;
  assign pin.x1   = c_x1_r;
  assign pin.x2   = c_x2_r;

  bpc_press u_press (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .cal   (cal),
    .pin   (pin),
    .pout  (pout)
  );

  ctx_t        k_ctx;
  logic [31:0] k_dvd;

  assign k_dvd      = pout.b7[31] ? pout.b7 : {pout.b7[30:0], 1'b0};
  assign k_ctx.a    = pout.b5;
  assign k_ctx.up   = '0;
  assign k_ctx.neg  = (pout.b4 == 32'd0);
  assign k_ctx.err  = pout.terr;
  assign k_ctx.flag = pout.b7[31];

  logic        p_vld;
  logic [31:0] p_quo;
  ctx_t        p_ctx;

  bpc_div u_pdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (pout.vld),
    .in_dvd    (k_dvd),
    .in_dvs    (pout.b4),
    .in_ctx    (k_ctx),
    .out_valid (p_vld),
    .out_quo   (p_quo),
    .out_ctx   (p_ctx)
  );

  logic        l_vld_r, m_vld_r, n_vld_r, o_vld_r;
  logic        l_terr_r, m_terr_r, n_terr_r, o_terr_r;
  logic        l_perr_r, m_perr_r, n_perr_r, o_perr_r;
  logic [31:0] l_b5_r, m_b5_r, n_b5_r, o_b5_r;
  logic [31:0] l_p_r, m_p_r, n_p_r, o_p_r;
  logic [31:0] m_sq_r, m_lin_r, n_m_r, n_lin_r, o_sum_r;
  logic [31:0] l_s, p_final;

  assign l_s     = asr(l_p_r, 8);
  assign p_final = o_p_r + asr(o_sum_r, 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_vld_r     <= 1'b0;
      m_vld_r     <= 1'b0;
      n_vld_r     <= 1'b0;
      o_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      l_vld_r     <= p_vld;
      m_vld_r     <= l_vld_r;
      n_vld_r     <= m_vld_r;
      o_vld_r     <= n_vld_r;
      out_valid_r <= o_vld_r;
    end
  end

  logic [31:0] out_term_r, out_pa_r;
  logic        out_err_r, out_terr_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      l_terr_r <= p_ctx.err;
      l_perr_r <= p_ctx.neg;
      l_b5_r   <= p_ctx.a;
      l_p_r    <= p_ctx.flag ? {p_quo[30:0], 1'b0} : p_quo;

      m_terr_r <= l_terr_r;
      m_perr_r <= l_perr_r;
      m_b5_r   <= l_b5_r;
      m_p_r    <= l_p_r;
      m_sq_r   <= l_s * l_s;
      m_lin_r  <= LinCoef * l_p_r;

      n_terr_r <= m_terr_r;
      n_perr_r <= m_perr_r;
      n_b5_r   <= m_b5_r;
      n_p_r    <= m_p_r;
      n_m_r    <= m_sq_r * SqCoef;
      n_lin_r  <= asr(m_lin_r, 16);

      o_terr_r <= n_terr_r;
      o_perr_r <= n_perr_r;
      o_b5_r   <= n_b5_r;
      o_p_r    <= n_p_r;
      o_sum_r  <= asr(n_m_r, 16) + n_lin_r + FinalOffset;

      out_terr_r <= o_terr_r;
      out_err_r  <= o_terr_r | o_perr_r;
      out_term_r <= o_terr_r ? 32'd0 : o_b5_r;
      out_pa_r   <= (o_terr_r | o_perr_r) ? 32'd0 : p_final;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.temperature_term = $signed(out_term_r);
  assign out_ch.pressure_pa      = $signed(out_pa_r);
  assign out_ch.divide_error     = out_err_r;

`ifndef SYNTHESIS
  a_reset_clears_output : assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid not cleared by reset");

  a_stall_holds_pipe : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(c_vld_r) && $stable(l_vld_r) && $stable(o_vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_rise_needs_advance : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv))
    else $error("result appeared without the pipeline advancing");

  a_temp_error_zeroes : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_terr_r |->
      out_err_r && (out_term_r == 32'd0) && (out_pa_r == 32'd0))
    else $error("temperature divisor error did not zero the results");
`endif

endmodule

[rtl/core/bpc_div.sv]
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Depends on bpc_pkg for the step function and the context type.
module bpc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        in_dvd,
  input  logic [31:0]        in_dvs,
  input  bpc_pkg::ctx_t      in_ctx,
  output logic               out_valid,
  output logic [31:0]        out_quo,
  output bpc_pkg::ctx_t      out_ctx
);
  import bpc_pkg::*;

  logic [31:0] rem_r [1:DivStages-1];
  logic [31:0] dvs_r [1:DivStages-1];
  logic [31:0] quo_r [1:DivStages];
  ctx_t        ctx_r [1:DivStages];
  logic        vld_r [1:DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [31:0] rem_s;
    logic [31:0] quo_s;
    logic [31:0] dvs_s;
    logic        vld_s;
    ctx_t        ctx_s;
    logic [63:0] step;

    if (k == 0) begin : g_first
      assign rem_s = '0;
      assign quo_s = in_dvd;
      assign dvs_s = in_dvs;
      assign vld_s = in_valid;
      assign ctx_s = in_ctx;
    end else begin : g_next
      assign rem_s = rem_r[k];
      assign quo_s = quo_r[k];
      assign dvs_s = dvs_r[k];
      assign vld_s = vld_r[k];
      assign ctx_s = ctx_r[k];
    end

    assign step = div_step(rem_s, quo_s, dvs_s);

    if (k < DivStages - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= step[63:32];
          dvs_r[k+1] <= dvs_s;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k+1] <= step[31:0];
        ctx_r[k+1] <= ctx_s;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_s;
      end
    end
  end

  assign out_valid = vld_r[DivStages];
  assign out_quo   = quo_r[DivStages];
  assign out_ctx   = ctx_r[DivStages];

endmodule

[rtl/core/bpc_press.sv]
// Pressure coefficient pipeline: from the temperature term to the divisor b4 and dividend b7.
// Depends on bpc_pkg for the calibration and stage record types.
module bpc_press (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  bpc_pkg::cal_t         cal,
  input  bpc_pkg::press_in_t    pin,
  output bpc_pkg::press_out_t   pout
);
  import bpc_pkg::*;

  logic        d_vld_r, e_vld_r, f_vld_r, g_vld_r, h_vld_r, i_vld_r, j_vld_r;
  logic        d_terr_r, e_terr_r, f_terr_r, g_terr_r, h_terr_r, i_terr_r, j_terr_r;
  logic [31:0] d_b5_r, e_b5_r, f_b5_r, g_b5_r, h_b5_r, i_b5_r, j_b5_r;
  logic [18:0] d_up_r, e_up_r, f_up_r, g_up_r, h_up_r;
  logic [31:0] d_b6_r;
  logic [31:0] e_sqp_r, e_ac2b6_r, e_ac3b6_r;
  logic [31:0] f_p1_r, f_p2_r, f_x2_r, f_x1_r;
  logic [31:0] g_x3a_r, g_x3b_r;
  logic [31:0] h_b3_r, h_t_r;
  logic [31:0] i_b4_r, i_diff_r;
  logic [31:0] j_b4_r, j_b7_r;

  logic [31:0] d_b5_nxt, d_b6_nxt, f_sq, h_b3_nxt, i_prod, j_scale;

  assign d_b5_nxt = pin.x1 + pin.x2;
  assign d_b6_nxt = pin.x1 + pin.x2 - TempOffset;
  assign f_sq     = asr(e_sqp_r, 12);
  assign h_b3_nxt = asr(((g_x3a_r + {cal.ac1[29:0], 2'b00}) << cal.oss) + RoundTwo, 2);
  assign i_prod   = cal.ac4 * h_t_r;
  assign j_scale  = {16'd0, PressScale >> cal.oss};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
      j_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= pin.vld;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
      g_vld_r <= f_vld_r;
      h_vld_r <= g_vld_r;
      i_vld_r <= h_vld_r;
      j_vld_r <= i_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_terr_r  <= pin.terr;
      d_up_r    <= pin.up;
      d_b5_r    <= d_b5_nxt;
      d_b6_r    <= d_b6_nxt;

      e_terr_r  <= d_terr_r;
      e_up_r    <= d_up_r;
      e_b5_r    <= d_b5_r;
      e_sqp_r   <= d_b6_r * d_b6_r;
      e_ac2b6_r <= cal.ac2 * d_b6_r;
      e_ac3b6_r <= cal.ac3 * d_b6_r;

      f_terr_r  <= e_terr_r;
      f_up_r    <= e_up_r;
      f_b5_r    <= e_b5_r;
      f_p1_r    <= cal.b2 * f_sq;
      f_p2_r    <= cal.b1 * f_sq;
      f_x2_r    <= asr(e_ac2b6_r, 11);
      f_x1_r    <= asr(e_ac3b6_r, 13);

      g_terr_r  <= f_terr_r;
      g_up_r    <= f_up_r;
      g_b5_r    <= f_b5_r;
      g_x3a_r   <= asr(f_p1_r, 11) + f_x2_r;
      g_x3b_r   <= asr(f_x1_r + asr(f_p2_r, 16) + RoundTwo, 2);

      h_terr_r  <= g_terr_r;
      h_up_r    <= g_up_r;
      h_b5_r    <= g_b5_r;
      h_b3_r    <= h_b3_nxt;
      h_t_r     <= g_x3b_r + HalfScale;

      i_terr_r  <= h_terr_r;
      i_b5_r    <= h_b5_r;
      i_b4_r    <= i_prod >> 15;
      i_diff_r  <= {13'd0, h_up_r} - h_b3_r;

      j_terr_r  <= i_terr_r;
      j_b5_r    <= i_b5_r;
      j_b4_r    <= i_b4_r;
      j_b7_r    <= i_diff_r * j_scale;
    end
  end

  assign pout.vld  = j_vld_r;
  assign pout.terr = j_terr_r;
  assign pout.b5   = j_b5_r;
  assign pout.b4   = j_b4_r;
  assign pout.b7   = j_b7_r;

endmodule
